[hdl/shelf_rectangle_packer_top_assert.svh]
// ----------------------------------------------------------------------------
// shelf_rectangle_packer_top_assert.svh
// Assertion macros used by the packer's checker.
// ----------------------------------------------------------------------------
`ifndef SHELF_RECTANGLE_PACKER_TOP_ASSERT_SVH
`define SHELF_RECTANGLE_PACKER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SRP_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define SRP_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[hdl/srp_pkg.sv]
// ----------------------------------------------------------------------------
// srp_pkg
// Field widths, register codes, reset values and control structs of the
// shelf rectangle packer.
// ----------------------------------------------------------------------------
package srp_pkg;

   localparam int SCALE_BITS     = 25;
   localparam int GAP_BITS       = 8;
   localparam int SIDE_BITS      = 14;
   localparam int GLYPH_BITS     = 14;
   localparam int OUT_BITS       = 16;
   localparam int OVF_BITS       = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 25;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 25'd16777216;
   localparam logic [GAP_BITS-1:0]   GAP_RESET   = 8'd8;
   localparam logic [SIDE_BITS-1:0]  SIDE_RESET  = 14'd1024;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCALE = 2'd0,
      CSR_GAP   = 2'd1,
      CSR_SIDE  = 2'd2
   } csr_index_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture a word and its scaled products
      logic place;   // update cursors, write a non-final result
      logic mult;    // overflow products
      logic emit;    // write the final result
   } srp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_last;
      logic out_free;
   } srp_stat_type;

endpackage

[hdl/srp_req_if.sv]
// ----------------------------------------------------------------------------
// srp_req_if
// Request channel: one unscaled glyph rectangle per word.
// ----------------------------------------------------------------------------
interface srp_req_if
   import srp_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [GLYPH_BITS-1:0] glyph_width;
   logic [GLYPH_BITS-1:0] glyph_height;
   logic                  is_last;

   modport source (output valid, glyph_width, glyph_height, is_last, input ready);
   modport sink   (input valid, glyph_width, glyph_height, is_last, output ready);
endinterface

[hdl/srp_rsp_if.sv]
// ----------------------------------------------------------------------------
// srp_rsp_if
// Response channel: placed position and, on the final word, the overflow.
// ----------------------------------------------------------------------------
interface srp_rsp_if
   import srp_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic [OUT_BITS-1:0]        place_x;
   logic [OUT_BITS-1:0]        place_y;
   logic signed [OVF_BITS-1:0] overflow;
   logic                       final_flag;

   modport source (output valid, place_x, place_y, overflow, final_flag, input ready);
   modport sink   (input valid, place_x, place_y, overflow, final_flag, output ready);
endinterface

[hdl/srp_ctrl.sv]
// ----------------------------------------------------------------------------
// srp_ctrl
// Sequencer of the packer: accept, place, and for the final word two more
// steps for the overflow term.
// ----------------------------------------------------------------------------
module srp_ctrl
   import srp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  srp_stat_type stat,
   output srp_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PLACE,
      ST_MULT,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            if (stat.is_last) begin
               cmd.place = 1'b1;
               state_in  = ST_MULT;
            end else if (stat.out_free) begin
               cmd.place = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

[hdl/srp_datapath.sv]
// ----------------------------------------------------------------------------
// srp_datapath
// Control registers, scaling multipliers, shelf cursors, overflow arithmetic
// and the response register.
// ----------------------------------------------------------------------------
module srp_datapath
   import srp_pkg::*;
#(
   parameter int COORD_BITS      = 16,
   parameter int SCALE_FRAC_BITS = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  srp_cmd_type                cmd,
   output srp_stat_type               stat,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_write_data,
   input  logic [GLYPH_BITS-1:0]      glyph_width,
   input  logic [GLYPH_BITS-1:0]      glyph_height,
   input  logic                       is_last,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [OUT_BITS-1:0]        place_x,
   output logic [OUT_BITS-1:0]        place_y,
   output logic signed [OVF_BITS-1:0] overflow,
   output logic                       final_flag
);

   localparam int C         = COORD_BITS;
   localparam int F         = SCALE_FRAC_BITS;
   localparam int PROD_BITS = SCALE_BITS + GLYPH_BITS;
   localparam int SW_BITS   = PROD_BITS + 1 - F;
   localparam int WIDE      = ((C > SW_BITS) ? C : SW_BITS) + 2;
   localparam int EY_BITS   = C + 2;
   localparam int TEY_BITS  = SIDE_BITS + EY_BITS;
   localparam int TT_BITS   = 2 * SIDE_BITS;
   localparam int OV_BITS   = ((WIDE > TEY_BITS) ? WIDE : TEY_BITS) + 2;

   localparam logic [C-1:0] COORD_MAX = '1;
   localparam logic signed [OV_BITS-1:0] OV_MAX = OV_BITS'(64'sd2147483647);
   localparam logic signed [OV_BITS-1:0] OV_MIN = OV_BITS'(-64'sd2147483648);

   function automatic logic [C-1:0] sat_coord(input logic [WIDE-1:0] v);
      return (v > WIDE'(COORD_MAX)) ? COORD_MAX : v[C-1:0];
   endfunction

   function automatic logic [OUT_BITS-1:0] sat_out(input logic [C-1:0] v);
      logic [WIDE-1:0] w;
      w = WIDE'(v);
      return (w > WIDE'(16'hFFFF)) ? 16'hFFFF : w[OUT_BITS-1:0];
   endfunction

   // control registers
   logic [SCALE_BITS-1:0] scale_ff;
   logic [GAP_BITS-1:0]   gap_ff;
   logic [SIDE_BITS-1:0]  side_ff;
   logic                  gap_write;

   assign gap_write = csr_write_enable && (csr_index == CSR_GAP);

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         gap_ff   <= GAP_RESET;
         side_ff  <= SIDE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCALE: scale_ff <= csr_write_data[SCALE_BITS-1:0];
            CSR_GAP:   gap_ff   <= csr_write_data[GAP_BITS-1:0];
            CSR_SIDE:  side_ff  <= csr_write_data[SIDE_BITS-1:0];
            default:   ;
         endcase
      end
   end

   // scaled products, taken with the word
   logic [PROD_BITS-1:0] prod_w_ff, prod_h_ff;
   logic                 last_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         prod_w_ff <= PROD_BITS'(scale_ff) * PROD_BITS'(glyph_width);
         prod_h_ff <= PROD_BITS'(scale_ff) * PROD_BITS'(glyph_height);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
      end else if (cmd.load) begin
         last_ff <= is_last;
      end
   end

   // placement
   logic [C-1:0]       cx_ff, cy_ff, rhm_ff;
   logic [C-1:0]       cx_in, cy_in, rhm_in;
   logic [SW_BITS-1:0] sw, sh;
   logic [WIDE-1:0]    need, h, gap_w;
   logic               wrap;
   logic [C-1:0]       cx_base, cy_base, rhm_base, rhm_new, gap_c;
   logic [EY_BITS-1:0] ey;
   logic [WIDE-1:0]    ex;

   // ceiling of product / 2^F: truncate, then bump on any fraction bit
   assign sw = SW_BITS'(prod_w_ff[PROD_BITS-1:F]) + SW_BITS'(|prod_w_ff[F-1:0]);
   assign sh = SW_BITS'(prod_h_ff[PROD_BITS-1:F]) + SW_BITS'(|prod_h_ff[F-1:0]);

   assign gap_w = WIDE'(gap_ff);
   assign gap_c = C'(gap_ff);
   assign need  = WIDE'(cx_ff) + WIDE'(1) + WIDE'(sw) + gap_w;
   assign wrap  = need > WIDE'(side_ff);
   assign h     = WIDE'(sh) + WIDE'(1);

   always_comb begin
      if (wrap) begin
         cx_base  = gap_c;
         cy_base  = sat_coord(WIDE'(cy_ff) + WIDE'(rhm_ff) + gap_w);
         rhm_base = '0;
      end else begin
         cx_base  = cx_ff;
         cy_base  = cy_ff;
         rhm_base = rhm_ff;
      end
      rhm_new = (h > WIDE'(rhm_base)) ? sat_coord(h) : rhm_base;
      ex      = WIDE'(cx_base) + gap_w + WIDE'(sw);
      ey      = EY_BITS'(cy_base) + EY_BITS'(gap_ff) + EY_BITS'(rhm_new);

      cx_in  = cx_ff;
      cy_in  = cy_ff;
      rhm_in = rhm_ff;
      if (gap_write) begin
         cx_in  = C'(csr_write_data[GAP_BITS-1:0]);
         cy_in  = C'(csr_write_data[GAP_BITS-1:0]);
         rhm_in = '0;
      end else if (cmd.place) begin
         if (last_ff) begin
            cx_in  = gap_c;
            cy_in  = gap_c;
            rhm_in = '0;
         end else begin
            cx_in  = sat_coord(WIDE'(cx_base) + WIDE'(1) + WIDE'(sw) + gap_w);
            cy_in  = cy_base;
            rhm_in = rhm_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= C'(GAP_RESET);
         cy_ff  <= C'(GAP_RESET);
         rhm_ff <= '0;
      end else begin
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         rhm_ff <= rhm_in;
      end
   end

   // final word: end position and overflow terms
   logic [OUT_BITS-1:0] px_hold_ff, py_hold_ff;
   logic [WIDE-1:0]     ex_ff;
   logic [EY_BITS-1:0]  ey_ff;
   logic [TEY_BITS-1:0] tey_ff;
   logic [TT_BITS-1:0]  tt_ff;

   always_ff @(posedge clock) begin
      if (cmd.place) begin
         px_hold_ff <= sat_out(cx_base);
         py_hold_ff <= sat_out(cy_base);
         ex_ff      <= ex;
         ey_ff      <= ey;
      end
      if (cmd.mult) begin
         tey_ff <= TEY_BITS'(side_ff) * TEY_BITS'(ey_ff);
         tt_ff  <= TT_BITS'(side_ff) * TT_BITS'(side_ff);
      end
   end

   logic signed [OV_BITS-1:0]  ov_sum;
   logic signed [OVF_BITS-1:0] ov_sat;

   assign ov_sum = $signed(OV_BITS'(ex_ff)) + $signed(OV_BITS'(tey_ff))
                 - $signed(OV_BITS'(tt_ff));

   always_comb begin
      if (ov_sum > OV_MAX) begin
         ov_sat = OVF_BITS'(OV_MAX);
      end else if (ov_sum < OV_MIN) begin
         ov_sat = OVF_BITS'(OV_MIN);
      end else begin
         ov_sat = OVF_BITS'(ov_sum);
      end
   end

   // response register
   logic                       rsp_valid_ff;
   logic [OUT_BITS-1:0]        place_x_ff, place_y_ff;
   logic signed [OVF_BITS-1:0] overflow_ff;
   logic                       final_flag_ff;
   logic                       out_free;
   logic                       write_plain;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign write_plain = cmd.place && !last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (write_plain || cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (write_plain) begin
         place_x_ff    <= sat_out(cx_base);
         place_y_ff    <= sat_out(cy_base);
         overflow_ff   <= '0;
         final_flag_ff <= 1'b0;
      end else if (cmd.emit) begin
         place_x_ff    <= px_hold_ff;
         place_y_ff    <= py_hold_ff;
         overflow_ff   <= ov_sat;
         final_flag_ff <= 1'b1;
      end
   end

   assign stat.is_last  = last_ff;
   assign stat.out_free = out_free;

   assign rsp_valid  = rsp_valid_ff;
   assign place_x    = place_x_ff;
   assign place_y    = place_y_ff;
   assign overflow   = overflow_ff;
   assign final_flag = final_flag_ff;

endmodule

[hdl/shelf_rectangle_packer_top.sv]
// A word is loaded with its scaled products, then placed; a non-final word
// waits for a free response register, a final word forms overflow products
// and is emitted when it is free. One word is in flight: each placement needs
// the previous cursor. The response register lets the next word be taken while
// a response waits. Reset (synchronous, active high): registers to their
// defaults, cursors at the gap, row height 0, no response pending.
// ----------------------------------------------------------------------------
// shelf_rectangle_packer_top
// Shelf packer for scaled glyph rectangles on a square texture.
// ----------------------------------------------------------------------------
module shelf_rectangle_packer_top
   import srp_pkg::*;
#(
   parameter int COORD_BITS      = 16,
   parameter int SCALE_FRAC_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   srp_req_if.sink                   req_chan,
   srp_rsp_if.source                 rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   srp_cmd_type  cmd;
   srp_stat_type stat;

   srp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   srp_datapath #(
      .COORD_BITS      (COORD_BITS),
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .glyph_width      (req_chan.glyph_width),
      .glyph_height     (req_chan.glyph_height),
      .is_last          (req_chan.is_last),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .place_x          (rsp_chan.place_x),
      .place_y          (rsp_chan.place_y),
      .overflow         (rsp_chan.overflow),
      .final_flag       (rsp_chan.final_flag)
   );

endmodule

[hdl/srp_checker.sv]
// ----------------------------------------------------------------------------
// srp_checker
// Port-level checks on the packer, bound to the top level.
// ----------------------------------------------------------------------------
`include "shelf_rectangle_packer_top_assert.svh"

module srp_checker
   import srp_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [OUT_BITS-1:0]        place_x,
   input logic [OUT_BITS-1:0]        place_y,
   input logic signed [OVF_BITS-1:0] overflow,
   input logic                       final_flag
);

   // one word in flight: ready drops right after an accept
   `SRP_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "ready after accept")

   // only the final word of a set carries an overflow value
   `SRP_ASSERT_NOW(a_overflow_only_final, rsp_valid && !final_flag, overflow == '0, "stray overflow")

   `SRP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")

   `SRP_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready,
      $stable(place_x) && $stable(place_y) && $stable(overflow) && $stable(final_flag),
      "stalled response changed")

endmodule

bind shelf_rectangle_packer_top srp_checker u_srp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .place_x    (rsp_chan.place_x),
   .place_y    (rsp_chan.place_y),
   .overflow   (rsp_chan.overflow),
   .final_flag (rsp_chan.final_flag)
);
